// ===== rtl/core/xkuv_pkg.sv =====
// Shared types, constants and a byte-class function for the xattr key UTF-8 validator.
// No dependencies; used by every module of the block.
package xkuv_pkg;

   localparam int OffsetBits = 16;
   localparam int LimitBits  = 16;
   localparam int LengthBits = 16;
   localparam int CmpBits    = (OffsetBits > LimitBits) ? OffsetBits : LimitBits;

   localparam logic [LimitBits-1:0]  MaxKeyLengthReset = LimitBits'(16);
   localparam logic [OffsetBits-1:0] OffsetMax         = {OffsetBits{1'b1}};

   localparam logic [7:0] ContMask   = 8'hC0;
   localparam logic [7:0] ContCode   = 8'h80;
   localparam logic [7:0] Lead2Mask  = 8'hE0;
   localparam logic [7:0] Lead2Code  = 8'hC0;
   localparam logic [7:0] Lead3Mask  = 8'hF0;
   localparam logic [7:0] Lead3Code  = 8'hE0;
   localparam logic [7:0] Lead4Mask  = 8'hF8;
   localparam logic [7:0] Lead4Code  = 8'hF0;
   localparam logic [7:0] AsciiLimit = 8'h80;
   localparam logic [7:0] CharUnder  = 8'h5F;
   localparam logic [7:0] CharDot    = 8'h2E;
   localparam logic [7:0] CharNul    = 8'h00;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic                  key_valid;
      logic [LengthBits-1:0] prefix_len;
   } rsp_payload_type;

   function automatic logic is_punct_or_ctrl(input logic [7:0] b);
      return b inside {[8'h00:8'h1F], 8'h7F, [8'h21:8'h2F], [8'h3A:8'h40],
                       [8'h5B:8'h60], [8'h7B:8'h7E]};
   endfunction

endpackage

// ===== rtl/core/xkuv_in_stage.sv =====
// Input register for request beats of the xattr key validator.
// Depends on xkuv_pkg for the request payload type.
module xkuv_in_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  xkuv_pkg::req_payload_type req_payload,
   output logic                      stage_valid,
   input  logic                      stage_ready,
   output xkuv_pkg::req_payload_type stage_payload
);

   logic                      valid_ff;
   logic                      valid_in;
   xkuv_pkg::req_payload_type payload_ff;

   assign req_ready     = !valid_ff || stage_ready;
   assign valid_in      = req_ready ? req_valid : valid_ff;
   assign stage_valid   = valid_ff;
   assign stage_payload = payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // load a new beat whenever the register is free or drains this cycle
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         payload_ff <= req_payload;
      end
   end

endmodule

// ===== rtl/core/xkuv_scan.sv =====
// Per-byte key scan state, rule checks and the registered result beat.
// Depends on xkuv_pkg for types, byte codes and the punctuation class.
module xkuv_scan (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                stage_valid,
   output logic                                stage_ready,
   input  xkuv_pkg::req_payload_type           stage_payload,
   input  logic [xkuv_pkg::LimitBits-1:0]      name_limit,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output xkuv_pkg::rsp_payload_type           rsp_payload
);

   logic [1:0]                      pending_ff, pending_in;
   logic [xkuv_pkg::OffsetBits-1:0] offset_ff, offset_in;
   logic [xkuv_pkg::OffsetBits-1:0] dot_offset_ff, dot_offset_in;
   logic                            dot_seen_ff, dot_seen_in;
   logic                            system_ff, system_in;
   logic                            error_ff, error_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   xkuv_pkg::rsp_payload_type       rsp_payload_ff, rsp_payload_in;

   logic                            advance;
   logic                            finish;
   logic [7:0]                      b;
   logic [xkuv_pkg::OffsetBits-1:0] dot;
   logic                            key_ok;

   assign b           = stage_payload.data_byte;
   assign stage_ready = !stage_payload.last_byte || !rsp_valid_ff || rsp_ready;
   assign advance     = stage_valid && stage_ready;
   assign finish      = advance && stage_payload.last_byte;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      pending_in    = pending_ff;
      offset_in     = (offset_ff == xkuv_pkg::OffsetMax) ? offset_ff
                                                        : offset_ff + 1'b1;
      dot_offset_in = dot_offset_ff;
      dot_seen_in   = dot_seen_ff;
      system_in     = system_ff;
      error_in      = error_ff;

      if (pending_ff != 2'd0) begin
         if ((b & xkuv_pkg::ContMask) == xkuv_pkg::ContCode) begin
            pending_in = pending_ff - 2'd1;
         end else begin
            error_in   = 1'b1;
            pending_in = 2'd0;
         end
      end else if (b < xkuv_pkg::AsciiLimit) begin
         if (offset_ff == '0 && xkuv_pkg::is_punct_or_ctrl(b)) begin
            if (b == xkuv_pkg::CharUnder) begin
               system_in = 1'b1;
            end else begin
               error_in = 1'b1;
            end
         end
         if (b == xkuv_pkg::CharDot && !dot_seen_ff) begin
            dot_seen_in   = 1'b1;
            dot_offset_in = offset_ff;
         end
         if (b == xkuv_pkg::CharNul) begin
            error_in = 1'b1;
         end
      end else if ((b & xkuv_pkg::Lead2Mask) == xkuv_pkg::Lead2Code) begin
         pending_in = 2'd1;
      end else if ((b & xkuv_pkg::Lead3Mask) == xkuv_pkg::Lead3Code) begin
         pending_in = 2'd2;
      end else if ((b & xkuv_pkg::Lead4Mask) == xkuv_pkg::Lead4Code) begin
         pending_in = 2'd3;
      end else begin
         error_in = 1'b1;
      end

      dot    = dot_seen_in ? dot_offset_in : offset_in;
      key_ok = !error_in && pending_in == 2'd0 && dot != '0
               && xkuv_pkg::CmpBits'(dot) < xkuv_pkg::CmpBits'(name_limit)
               && !(system_in && dot == xkuv_pkg::OffsetBits'(1));

      rsp_payload_in.key_valid  = key_ok;
      rsp_payload_in.prefix_len = key_ok ? xkuv_pkg::LengthBits'(dot) : '0;

      rsp_valid_in = finish || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= 2'd0;
         offset_ff     <= '0;
         dot_offset_ff <= '0;
         dot_seen_ff   <= 1'b0;
         system_ff     <= 1'b0;
         error_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (finish) begin
            pending_ff    <= 2'd0;
            offset_ff     <= '0;
            dot_offset_ff <= '0;
            dot_seen_ff   <= 1'b0;
            system_ff     <= 1'b0;
            error_ff      <= 1'b0;
         end else if (advance) begin
            pending_ff    <= pending_in;
            offset_ff     <= offset_in;
            dot_offset_ff <= dot_offset_in;
            dot_seen_ff   <= dot_seen_in;
            system_ff     <= system_in;
            error_ff      <= error_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

endmodule

// ===== rtl/core/xattr_key_utf8_validator_top.sv =====
// Top level of the xattr key UTF-8 validator: input register, scan unit, limit register.
// Depends on xkuv_pkg, xkuv_in_stage and xkuv_scan.
// Result beat: valid in the cycle after the scan unit accepts the last key byte; the input
// register and the result register lie between that byte's handshake and the result's.
// Throughput: one byte per cycle; a last byte waits only while an older result beat stalls.
// Reset: synchronous, clears scan state and both valid flags; limit returns to 16.
module xattr_key_utf8_validator_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  xkuv_pkg::req_payload_type         req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output xkuv_pkg::rsp_payload_type         rsp_payload,
   input  logic                              csr_write_enable,
   input  logic [xkuv_pkg::LimitBits-1:0]    csr_write_data
);

   logic [xkuv_pkg::LimitBits-1:0] name_limit_ff;
   logic                           stage_valid;
   logic                           stage_ready;
   xkuv_pkg::req_payload_type      stage_payload;

   always_ff @(posedge clock) begin
      if (reset) begin
         name_limit_ff <= xkuv_pkg::MaxKeyLengthReset;
      end else if (csr_write_enable) begin
         name_limit_ff <= csr_write_data;
      end
   end

   xkuv_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .stage_valid   (stage_valid),
      .stage_ready   (stage_ready),
      .stage_payload (stage_payload)
   );

   xkuv_scan u_scan (
      .clock          (clock),
      .reset          (reset),
      .stage_valid    (stage_valid),
      .stage_ready    (stage_ready),
      .stage_payload  (stage_payload),
      .name_limit     (name_limit_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload)
   );

   a_invalid_zero_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.key_valid |-> rsp_payload.prefix_len == '0)
      else $error("invalid key reported with nonzero length");

   a_valid_nonzero_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.key_valid |-> rsp_payload.prefix_len != '0)
      else $error("valid key reported with zero length");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      stage_valid && !stage_ready |=> stage_valid && $stable(stage_payload))
      else $error("stalled input register lost its beat");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for xattr_key_utf8_validator_top: random and directed keys, a byte
// per beat, checked against a built-in scan predictor. Depends on xkuv_pkg and the RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 1_000_000;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   xkuv_pkg::req_payload_type      req_payload = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   xkuv_pkg::rsp_payload_type      rsp_payload;
   logic                           csr_write_enable = 1'b0;
   logic [xkuv_pkg::LimitBits-1:0] csr_write_data = '0;

   xattr_key_utf8_validator_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // scan predictor state
   logic [xkuv_pkg::LimitBits-1:0]  key_limit = xkuv_pkg::MaxKeyLengthReset;
   logic [1:0]                      pend_cont = '0;
   logic [xkuv_pkg::OffsetBits-1:0] byte_pos = '0;
   logic [xkuv_pkg::OffsetBits-1:0] dot_pos = '0;
   bit                              dot_found = 1'b0;
   bit                              sys_key = 1'b0;
   bit                              key_error = 1'b0;

   xkuv_pkg::req_payload_type pending_beats[$];
   xkuv_pkg::rsp_payload_type expected_verdicts[$];
   logic [7:0]                key_buf[$];
   logic [15:0]               key_limits [0:8] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd8,
                                                   16'd16, 16'd31, 16'd1000, 16'd65535};

   int  cycle_count = 0;
   int  mismatch_count = 0;
   int  key_count = 0;
   int  verdict_count = 0;
   int  beat_count = 0;
   int  send_idle_pct = 30;
   int  recv_idle_pct = 30;
   bit  calm = 1'b0;

   function automatic bit is_symbol_or_control(input logic [7:0] c);
      bit alnum;
      alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
              (c >= 8'h61 && c <= 8'h7A);
      return c < xkuv_pkg::AsciiLimit && c != 8'h20 && !alnum;
   endfunction

   function automatic bit scan_key_byte(input xkuv_pkg::req_payload_type beat,
                                        output xkuv_pkg::rsp_payload_type verdict);
      logic [7:0]                      b;
      logic [xkuv_pkg::OffsetBits-1:0] pos;
      logic [xkuv_pkg::OffsetBits-1:0] span;
      bit                              ok;
      b = beat.data_byte;
      pos = byte_pos;
      verdict = '0;
      if (byte_pos != xkuv_pkg::OffsetMax) byte_pos++;
      if (pend_cont != 0) begin
         if ((b & xkuv_pkg::ContMask) == xkuv_pkg::ContCode) pend_cont--;
         else begin
            key_error = 1'b1;
            pend_cont = '0;
         end
      end else if (b < xkuv_pkg::AsciiLimit) begin
         if (pos == 0 && is_symbol_or_control(b)) begin
            if (b == xkuv_pkg::CharUnder) sys_key = 1'b1;
            else key_error = 1'b1;
         end
         if (b == xkuv_pkg::CharDot && !dot_found) begin
            dot_found = 1'b1;
            dot_pos = pos;
         end
         if (b == xkuv_pkg::CharNul) key_error = 1'b1;
      end else if ((b & xkuv_pkg::Lead2Mask) == xkuv_pkg::Lead2Code) begin
         pend_cont = 2'd1;
      end else if ((b & xkuv_pkg::Lead3Mask) == xkuv_pkg::Lead3Code) begin
         pend_cont = 2'd2;
      end else if ((b & xkuv_pkg::Lead4Mask) == xkuv_pkg::Lead4Code) begin
         pend_cont = 2'd3;
      end else begin
         key_error = 1'b1;
      end
      if (!beat.last_byte) return 1'b0;
      if (pend_cont != 0) key_error = 1'b1;
      span = dot_found ? dot_pos : byte_pos;
      ok = !key_error && span != 0 && span < key_limit && !(sys_key && span == 1);
      verdict.key_valid = ok;
      verdict.prefix_len = ok ? span : '0;
      pend_cont = '0;
      byte_pos = '0;
      dot_pos = '0;
      dot_found = 1'b0;
      sys_key = 1'b0;
      key_error = 1'b0;
      return 1'b1;
   endfunction

   task automatic flag_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   function automatic logic [7:0] random_alnum();
      case ($urandom_range(0, 2))
         0: return 8'h30 + 8'($urandom_range(0, 9));
         1: return 8'h41 + 8'($urandom_range(0, 25));
         default: return 8'h61 + 8'($urandom_range(0, 25));
      endcase
   endfunction

   function automatic logic [7:0] random_lead(input int width);
      case (width)
         2: return xkuv_pkg::Lead2Code | 8'($urandom_range(0, 31));
         3: return xkuv_pkg::Lead3Code | 8'($urandom_range(0, 15));
         default: return xkuv_pkg::Lead4Code | 8'($urandom_range(0, 7));
      endcase
   endfunction

   task automatic push_multibyte();
      int width;
      width = $urandom_range(2, 4);
      key_buf.push_back(random_lead(width));
      for (int k = 1; k < width; k++)
         key_buf.push_back(xkuv_pkg::ContCode | 8'($urandom_range(0, 63)));
   endtask

   task automatic build_random_key(input int cap);
      int n;
      int r;
      n = $urandom_range(1, cap);
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         if (k == 0) begin
            if (r < 65) key_buf.push_back(random_alnum());
            else if (r < 77) key_buf.push_back(xkuv_pkg::CharUnder);
            else if (r < 87) push_multibyte();
            else if (r < 93) key_buf.push_back(8'($urandom_range(0, 127)));
            else key_buf.push_back(8'($urandom_range(0, 255)));
         end else begin
            if (r < 55) key_buf.push_back(random_alnum());
            else if (r < 65) key_buf.push_back(xkuv_pkg::CharDot);
            else if (r < 82) push_multibyte();
            else if (r < 90) key_buf.push_back(8'($urandom_range(32, 126)));
            else if (r < 93) key_buf.push_back(xkuv_pkg::CharNul);
            else key_buf.push_back(8'($urandom_range(0, 255)));
         end
      end
      if ($urandom_range(0, 99) < 5) key_buf.push_back(random_lead($urandom_range(2, 4)));
   endtask

   task automatic commit_key();
      xkuv_pkg::req_payload_type beat;
      foreach (key_buf[i]) begin
         beat.data_byte = key_buf[i];
         beat.last_byte = (i == key_buf.size() - 1);
         pending_beats.push_back(beat);
      end
      key_count++;
      key_buf.delete();
   endtask

   task automatic drain();
      while (verdict_count < key_count) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_key_limit(input logic [xkuv_pkg::LimitBits-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      key_limit = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   always @(posedge clock) begin : drive_beats
      int                        gap_left;
      bit                        next_valid;
      xkuv_pkg::req_payload_type next_payload;
      xkuv_pkg::rsp_payload_type verdict;
      if (reset) begin
         gap_left = 0;
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         next_payload = req_payload;
         if (req_valid && req_ready) begin
            beat_count++;
            if (scan_key_byte(req_payload, verdict)) expected_verdicts.push_back(verdict);
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_beats.size() != 0) begin
               if (!calm && $urandom_range(0, 99) < send_idle_pct) begin
                  gap_left = $urandom_range(0, 3);
               end else begin
                  next_payload = pending_beats.pop_front();
                  next_valid = 1'b1;
               end
            end
         end
         req_valid <= next_valid;
         req_payload <= next_payload;
      end
   end

   always @(posedge clock) begin : watch_verdicts
      int                        stall_left;
      xkuv_pkg::rsp_payload_type want;
      if (reset) begin
         stall_left = 0;
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            verdict_count++;
            if (expected_verdicts.size() == 0) begin
               flag_mismatch("result beat with nothing expected");
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_payload.key_valid !== want.key_valid)
                  flag_mismatch($sformatf("key_valid got %b want %b",
                                          rsp_payload.key_valid, want.key_valid));
               if (rsp_payload.prefix_len !== want.prefix_len)
                  flag_mismatch($sformatf("prefix_len got %0d want %0d",
                                          rsp_payload.prefix_len, want.prefix_len));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 99) < recv_idle_pct) begin
            stall_left = $urandom_range(0, 3);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("run timed out at cycle %0d", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int quota;
      int cap;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      key_buf = {8'h61};                                commit_key();
      key_buf = {xkuv_pkg::CharUnder};                  commit_key();
      key_buf = {xkuv_pkg::CharUnder, 8'h61};           commit_key();
      key_buf = {xkuv_pkg::CharDot};                    commit_key();
      key_buf = {8'h61, xkuv_pkg::CharDot, 8'h62};      commit_key();
      key_buf = {xkuv_pkg::CharNul};                    commit_key();
      key_buf = {8'hFF};                                commit_key();
      key_buf = {8'h80};                                commit_key();
      key_buf = {8'hC3, 8'hA9};                         commit_key();
      key_buf = {8'hE2, 8'h82, 8'hAC};                  commit_key();
      key_buf = {8'hF0, 8'h9F, 8'h98, 8'h80};           commit_key();
      key_buf = {8'hE2, 8'h82};                         commit_key();
      key_buf = {8'hC3, 8'h41};                         commit_key();
      drain();

      foreach (key_limits[p]) begin
         calm = (p == 8);
         set_key_limit(key_limits[p]);
         send_idle_pct = 20 * $urandom_range(0, 3);
         recv_idle_pct = 20 * $urandom_range(0, 3);
         cap = (key_limits[p] < 4) ? 8 : ((key_limits[p] > 20) ? 24 : key_limits[p] + 4);
         quota = calm ? 100 : 160;
         while (quota > 0) begin
            build_random_key(cap);
            quota -= key_buf.size();
            commit_key();
         end
         drain();
      end

      repeat (8) @(posedge clock);
      if (expected_verdicts.size() != 0) flag_mismatch("expected results left over");
      $display("%0d keys in %0d byte beats, %0d results checked", key_count, beat_count,
               verdict_count);
      $display("limit register swept over nine values from 0 to 65535; stray, cut-short "
               , "and mixed UTF-8 sequences under random idling");
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/xkuv_pkg.sv
rtl/core/xkuv_in_stage.sv
rtl/core/xkuv_scan.sv
rtl/core/xattr_key_utf8_validator_top.sv
tb/sv/tb_top.sv
